/* rtl/core/sdv_pkg.sv */
// Package: shared types and constants of the sphere distance voxelizer.
package sdv_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned OFS_W   = 32;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned AXES    = 3;
  localparam int unsigned PROD_W  = IDX_W + CFG_W;
  localparam int unsigned MAG_W   = PROD_W + 1;
  localparam int unsigned HALF_W  = MAG_W / 2;
  localparam int unsigned PP_W    = 2 * HALF_W;
  localparam int unsigned SQ_W    = 2 * MAG_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned DIFF_W  = 34;
  localparam int unsigned DIST_W  = 64;
  localparam int unsigned SCL_W   = DIFF_W + 17;
  localparam int unsigned VOX_W   = 16;

  localparam logic signed [16:0] VoxelMax = 17'sd32767;

  typedef enum logic [2:0] {
    CFG_OFFSET_X     = 3'd0,
    CFG_OFFSET_Y     = 3'd1,
    CFG_OFFSET_Z     = 3'd2,
    CFG_RADIUS       = 3'd3,
    CFG_STEP_X       = 3'd4,
    CFG_STEP_Y       = 3'd5,
    CFG_STEP_Z       = 3'd6,
    CFG_INV_DIAGONAL = 3'd7
  } cfg_idx_e;

endpackage

/* rtl/core/sphere_distance_voxelizer.sv */
// Top level: pipelined sphere signed-distance voxel evaluator.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in       | sink      | in_valid_i/in_stall_o | x_index_i, y_index_i, z_index_i
//  out      | source    | out_valid_o/out_stall_i | voxel_value_o
//  cfg      | sink      | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One request per cycle while the output is not stalled; the pipe is the 43-stage
// bit-per-stage square root plus 5 front and 4 back stages.
// All stages advance together; a stall on the output stalls the whole pipe, so
// the input stalls only while a finished result waits at the output.
// Reset clears valid bits and loads the register reset values.
module sphere_distance_voxelizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sdv_pkg::IDX_W-1:0]    x_index_i,
  input  logic [sdv_pkg::IDX_W-1:0]    y_index_i,
  input  logic [sdv_pkg::IDX_W-1:0]    z_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [sdv_pkg::VOX_W-1:0] voxel_value_o,
  input  logic                         cfg_we_i,
  input  sdv_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [sdv_pkg::DATA_W-1:0]   cfg_data_i
);
  import sdv_pkg::*;

  localparam int unsigned NSTG = ROOT_W + 9;

  logic signed [OFS_W-1:0] ofs_q [AXES];
  logic [CFG_W-1:0]        step_q [AXES];
  logic [CFG_W-1:0]        radius_q, inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        ofs_q[a]  <= '0;
        step_q[a] <= CFG_W'(65536);
      end
      radius_q <= CFG_W'(65536);
      inv_q    <= CFG_W'(37837);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET_X:     ofs_q[0]  <= cfg_data_i;
        CFG_OFFSET_Y:     ofs_q[1]  <= cfg_data_i;
        CFG_OFFSET_Z:     ofs_q[2]  <= cfg_data_i;
        CFG_RADIUS:       radius_q  <= cfg_data_i[CFG_W-1:0];
        CFG_STEP_X:       step_q[0] <= cfg_data_i[CFG_W-1:0];
        CFG_STEP_Y:       step_q[1] <= cfg_data_i[CFG_W-1:0];
        CFG_STEP_Z:       step_q[2] <= cfg_data_i[CFG_W-1:0];
        CFG_INV_DIAGONAL: inv_q     <= cfg_data_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            en, acc;
  logic [NSTG-1:0] vld_q;

  assign in_stall_o  = out_valid_o & out_stall_i;
  assign en          = ~in_stall_o;
  assign acc         = in_valid_i & en;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], acc};
    end
  end

  // front: index times step, magnitude, partial squares, sums
  logic [IDX_W-1:0]  idx_a [AXES];
  logic [PROD_W-1:0] prod_q [AXES];
  logic [MAG_W-1:0]  mag_q [AXES];
  logic [PP_W-1:0]   hh_q [AXES], hl_q [AXES], ll_q [AXES];
  logic [SQ_W-1:0]   sq_q [AXES];
  logic [SUM_W-1:0]  sum_q;
  logic signed [MAG_W:0] rel_d [AXES];

  assign idx_a[0] = x_index_i;
  assign idx_a[1] = y_index_i;
  assign idx_a[2] = z_index_i;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rel_d[a] = $signed({2'b00, prod_q[a]}) - (MAG_W+1)'(ofs_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        prod_q[a] <= PROD_W'(idx_a[a]) * PROD_W'(step_q[a]);
        mag_q[a]  <= rel_d[a][MAG_W] ? MAG_W'(-rel_d[a]) : MAG_W'(rel_d[a]);
        hh_q[a]   <= PP_W'(mag_q[a][MAG_W-1:HALF_W]) * PP_W'(mag_q[a][MAG_W-1:HALF_W]);
        hl_q[a]   <= PP_W'(mag_q[a][MAG_W-1:HALF_W]) * PP_W'(mag_q[a][HALF_W-1:0]);
        ll_q[a]   <= PP_W'(mag_q[a][HALF_W-1:0]) * PP_W'(mag_q[a][HALF_W-1:0]);
        sq_q[a]   <= (SQ_W'(hh_q[a]) << PP_W) + (SQ_W'(hl_q[a]) << (HALF_W + 1))
                   + SQ_W'(ll_q[a]);
      end
      sum_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
  end

  // square root, one result bit per stage
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SUM_W-1:0]  rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W+1:0]  cat;
    logic [REM_W+2:0]  trl;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign cat = {rem_in, rad_in[SUM_W-1 -: 2]};
    assign trl = {1'b0, cat} - {3'b000, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k] <= rad_in << 2;
        if (!trl[REM_W+2]) begin
          rem_q[k]  <= trl[REM_W-1:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cat[REM_W-1:0];
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // back: clamp, scale by inverse diagonal, saturate, round
  localparam logic signed [ROOT_W+1:0] DiffHi = (ROOT_W+2)'(64'sh1_0000_0000);
  localparam logic signed [ROOT_W+1:0] DiffLo = -DiffHi;
  localparam logic signed [DIST_W-1:0] OneQ   = 64'sh1_0000_0000;

  logic signed [ROOT_W+1:0] diff_d;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [DIST_W-1:0] dist_q;
  logic signed [SCL_W-1:0]  scl_q;
  logic                     sat_pos_q, sat_neg_q;
  logic signed [SCL_W:0]    rnd_d;
  logic signed [VOX_W-1:0]  vox_q;

  assign diff_d = $signed((ROOT_W+2)'(radius_q)) - $signed({2'b00, root_q[ROOT_W-1]});

  always_comb begin
    if (scl_q < -$signed(SCL_W'(64'sh8000_0000))) begin
      rnd_d = (SCL_W+1)'(scl_q) + (SCL_W+1)'(64'sh1_7FFF_FFFF);
    end else begin
      rnd_d = (SCL_W+1)'(scl_q) + (SCL_W+1)'(64'sh8000_0000);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (diff_d > DiffHi) begin
        diff_q <= DIFF_W'(DiffHi);
      end else if (diff_d < DiffLo) begin
        diff_q <= DIFF_W'(DiffLo);
      end else begin
        diff_q <= DIFF_W'(diff_d);
      end
      dist_q    <= DIST_W'(diff_q) * DIST_W'($signed({1'b0, inv_q}));
      sat_pos_q <= dist_q >= OneQ;
      sat_neg_q <= dist_q <= -OneQ;
      scl_q     <= SCL_W'($signed(dist_q[DIFF_W-1:0])) * SCL_W'(VoxelMax);
      if (sat_pos_q) begin
        vox_q <= VOX_W'(VoxelMax);
      end else if (sat_neg_q) begin
        vox_q <= VOX_W'(-VoxelMax);
      end else begin
        vox_q <= rnd_d[32 +: VOX_W];
      end
    end
  end

  assign voxel_value_o = vox_q;

endmodule

/* rtl/core/sdv_checker.sv */
// Checker: port-level properties of the sphere distance voxelizer, with its bind.
module sdv_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [sdv_pkg::VOX_W-1:0]  voxel_value_o
);
  import sdv_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(voxel_value_o))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> voxel_value_o <= VoxelMax && voxel_value_o >= -VoxelMax)
    else $error("voxel value beyond saturation limit");

endmodule

bind sphere_distance_voxelizer sdv_checker u_sdv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .voxel_value_o (voxel_value_o)
);
